>>> rtl/sstm_pkg.sv
// Package with the register map, register widths and reset values of the slanted strip tiling map.
package sstm_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 24;

	localparam int COS_W    = 17;
	localparam int SIN_W    = 17;
	localparam int HEIGHT_W = 18;
	localparam int INV_W    = 24;
	localparam int SHIFT_W  = 24;
	localparam int SCALE_W  = 24;

	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
	typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

	localparam cfg_index_t REG_COS    = 3'd0;
	localparam cfg_index_t REG_SIN    = 3'd1;
	localparam cfg_index_t REG_HEIGHT = 3'd2;
	localparam cfg_index_t REG_INV    = 3'd3;
	localparam cfg_index_t REG_SHIFT  = 3'd4;
	localparam cfg_index_t REG_SCALE  = 3'd5;

	localparam logic [COS_W-1:0]    COS_RESET    = 17'd58617;
	localparam logic [SIN_W-1:0]    SIN_RESET    = 17'd29309;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 18'd58617;
	localparam logic [INV_W-1:0]    INV_RESET    = 24'd73271;
	localparam logic [SHIFT_W-1:0]  SHIFT_RESET  = 24'd131072;
	localparam logic [SCALE_W-1:0]  SCALE_RESET  = 24'd73271;

endpackage

>>> rtl/sstm_if.sv
// Interfaces for the coordinate input, result output and configuration write channels.
interface sstm_dest_if #(
	parameter int COORD_WIDTH = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] dest_x;
	logic signed [COORD_WIDTH-1:0] dest_y;

	modport source (output valid, output dest_x, output dest_y, input ready);
	modport sink (input valid, input dest_x, input dest_y, output ready);
endinterface

interface sstm_src_if #(
	parameter int FRAC_BITS   = 16,
	parameter int COORD_WIDTH = 24
);
	logic                          valid;
	logic                          ready;
	logic signed [FRAC_BITS:0]     src_x;
	logic signed [COORD_WIDTH-1:0] src_y;

	modport source (output valid, output src_x, output src_y, input ready);
	modport sink (input valid, input src_x, input src_y, output ready);
endinterface

interface sstm_cfg_if
	import sstm_pkg::*;
();
	logic       valid;
	logic       ready;
	cfg_index_t index;
	cfg_data_t  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/slanted_strip_tiling_map_core.sv
// Top level of the slanted strip tiling map: an eight stage coordinate mapping pipeline.
//
// One destination coordinate is taken per cycle unless a stalled output has filled the pipeline, and
// its source coordinate leaves from the last stage. The depth is set by four dependent
// multiplications (rotation, reciprocal of the strip height, strip offset and final
// scale), each followed by a stage for its add, rounding or saturation. Every stage
// holds its own valid bit and loads whenever it is empty or its successor moves, so
// bubbles close up behind a stalled output and nothing is lost or repeated.
// Configuration writes are taken in every cycle and must only be issued while the
// pipeline is empty.
module slanted_strip_tiling_map_core
	import sstm_pkg::*;
#(
	parameter int FRAC_BITS   = 16,
	parameter int COORD_WIDTH = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	sstm_dest_if.sink    dest,
	sstm_src_if.source   src,
	sstm_cfg_if.sink     cfg
);

	localparam int CW     = COORD_WIDTH;
	localparam int F      = FRAC_BITS;
	localparam int STAGES = 8;
	localparam int MW     = CW + COS_W + 1;
	localparam int RW     = MW + 1;
	localparam int PW     = CW + INV_W + 1;
	localparam int DW     = CW - 1;
	localparam int HW     = DW + HEIGHT_W + 1;
	localparam int YW     = (HW > CW ? HW : CW) + 1;
	localparam int SW     = DW + SHIFT_W + 1;
	localparam int XW     = (SW > CW ? SW : CW) + 1;
	localparam int OW     = CW + SCALE_W + 1;

	logic [COS_W-1:0]    cos_q;
	logic [SIN_W-1:0]    sin_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [INV_W-1:0]    inv_q;
	logic [SHIFT_W-1:0]  shift_q;
	logic [SCALE_W-1:0]  scale_q;

	logic [STAGES:1]   vld_q;
	logic [STAGES+1:1] en;

	logic signed [MW-1:0] xc_s1, ys_s1, yc_s1, xs_s1;
	logic signed [CW-1:0] rx_s2, ry_s2, rx_s3, ry_s3, rx_s4, ry_s4, rx_s5, ry_s5;
	logic signed [PW-1:0] p_s3;
	logic signed [DW-1:0] d_s4;
	logic signed [HW-1:0] hd_s5;
	logic signed [SW-1:0] sd_s5;
	logic signed [CW-1:0] sx_s6, sy_s6;
	logic signed [OW-1:0] ox_s7, oy_s7;
	logic signed [F:0]    src_x_s8;
	logic signed [CW-1:0] src_y_s8;

	logic signed [RW-1:0] rx_sum, ry_sum, rx_sh, ry_sh;
	logic signed [PW-1:0] d_half, d_full;
	logic signed [YW-1:0] y_diff;
	logic signed [XW-1:0] x_sum;
	logic signed [OW-1:0] ox_sh, oy_sh;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q    <= COS_RESET;
			sin_q    <= SIN_RESET;
			height_q <= HEIGHT_RESET;
			inv_q    <= INV_RESET;
			shift_q  <= SHIFT_RESET;
			scale_q  <= SCALE_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_COS:    cos_q    <= cfg.data[COS_W-1:0];
				REG_SIN:    sin_q    <= cfg.data[SIN_W-1:0];
				REG_HEIGHT: height_q <= cfg.data[HEIGHT_W-1:0];
				REG_INV:    inv_q    <= cfg.data[INV_W-1:0];
				REG_SHIFT:  shift_q  <= cfg.data[SHIFT_W-1:0];
				REG_SCALE:  scale_q  <= cfg.data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// A stage loads when it is empty or when the stage after it moves on.
	always_comb begin
		en[STAGES+1] = src.ready;
		for (int k = STAGES; k >= 1; k--) begin
			en[k] = ~vld_q[k] | en[k+1];
		end
	end

	assign dest.ready = en[1];
	assign src.valid  = vld_q[STAGES];
	assign src.src_x  = src_x_s8;
	assign src.src_y  = src_y_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= dest.valid;
			end
			for (int k = 2; k <= STAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	always_comb begin
		rx_sum = RW'(xc_s1) + RW'(ys_s1);
		ry_sum = RW'(yc_s1) - RW'(xs_s1);
		rx_sh  = rx_sum >>> F;
		ry_sh  = ry_sum >>> F;
		d_half = (p_s3 >>> (2 * F - 1)) + PW'(1);
		d_full = d_half >>> 1;
		y_diff = YW'(ry_s5) - YW'(hd_s5);
		x_sum  = XW'(rx_s5) + XW'(sd_s5);
		ox_sh  = ox_s7 >>> F;
		oy_sh  = oy_s7 >>> F;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			xc_s1 <= MW'(dest.dest_x * $signed({1'b0, cos_q}));
			ys_s1 <= MW'(dest.dest_y * $signed({1'b0, sin_q}));
			yc_s1 <= MW'(dest.dest_y * $signed({1'b0, cos_q}));
			xs_s1 <= MW'(dest.dest_x * $signed({1'b0, sin_q}));
		end
		if (en[2]) begin
			rx_s2 <= (rx_sh[RW-1:CW-1] != {(RW-CW+1){rx_sh[RW-1]}}) ?
				{rx_sh[RW-1], {(CW-1){~rx_sh[RW-1]}}} : rx_sh[CW-1:0];
			ry_s2 <= (ry_sh[RW-1:CW-1] != {(RW-CW+1){ry_sh[RW-1]}}) ?
				{ry_sh[RW-1], {(CW-1){~ry_sh[RW-1]}}} : ry_sh[CW-1:0];
		end
		if (en[3]) begin
			p_s3  <= PW'(ry_s2 * $signed({1'b0, inv_q}));
			rx_s3 <= rx_s2;
			ry_s3 <= ry_s2;
		end
		if (en[4]) begin
			d_s4 <= (d_full[PW-1:DW-1] != {(PW-DW+1){d_full[PW-1]}}) ?
				{d_full[PW-1], {(DW-1){~d_full[PW-1]}}} : d_full[DW-1:0];
			rx_s4 <= rx_s3;
			ry_s4 <= ry_s3;
		end
		if (en[5]) begin
			hd_s5 <= HW'(d_s4 * $signed({1'b0, height_q}));
			sd_s5 <= SW'(d_s4 * $signed({1'b0, shift_q}));
			rx_s5 <= rx_s4;
			ry_s5 <= ry_s4;
		end
		if (en[6]) begin
			sy_s6 <= (y_diff[YW-1:CW-1] != {(YW-CW+1){y_diff[YW-1]}}) ?
				{y_diff[YW-1], {(CW-1){~y_diff[YW-1]}}} : y_diff[CW-1:0];
			sx_s6 <= (x_sum[XW-1:CW-1] != {(XW-CW+1){x_sum[XW-1]}}) ?
				{x_sum[XW-1], {(CW-1){~x_sum[XW-1]}}} : x_sum[CW-1:0];
		end
		if (en[7]) begin
			ox_s7 <= OW'(sx_s6 * $signed({1'b0, scale_q}));
			oy_s7 <= OW'(sy_s6 * $signed({1'b0, scale_q}));
		end
		if (en[8]) begin
			// Taking the low bits is the exact wrap of x into [-1, 1).
			src_x_s8 <= ox_sh[F:0];
			src_y_s8 <= (oy_sh[OW-1:CW-1] != {(OW-CW+1){oy_sh[OW-1]}}) ?
				{oy_sh[OW-1], {(CW-1){~oy_sh[OW-1]}}} : oy_sh[CW-1:0];
		end
	end

`ifndef SYNTHESIS
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!src.valid |-> dest.ready)
		else $error("input not ready although the output stage is empty");

	a_transfer_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(dest.valid && dest.ready) |=> vld_q[1])
		else $error("input transfer did not reach the first stage");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(src.valid && src.ready && !vld_q[STAGES-1]) |=> !src.valid)
		else $error("result repeated after its transfer");
`endif

endmodule

>>> verif/slanted_strip_tiling_map_core_test.sv
`timescale 1ns / 1ps
// Bench of the map core: a directed script, then random settings and coords; checked by predictor or script rows.
module slanted_strip_tiling_map_core_test;
	import sstm_pkg::*;

	localparam int FRAC_BITS     = 16;
	localparam int COORD_WIDTH   = 24;
	localparam int SRCX_W        = FRAC_BITS + 1;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 200;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int DRAIN_CYCLES  = 16;
	localparam int REPORT_MAX    = 100;
	localparam cfg_index_t REG_SPARE = 3'd6;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [SRCX_W-1:0]      wrap_t;

	typedef struct packed {
		wrap_t  src_x;
		coord_t src_y;
	} src_coord_t;

	typedef enum logic { ROW_CFG, ROW_ITEM } row_kind_e;

	typedef struct packed {
		row_kind_e              kind;
		cfg_index_t             index;
		logic [COORD_WIDTH-1:0] a;
		logic [COORD_WIDTH-1:0] b;
		logic                   known;
		wrap_t                  ex;
		coord_t                 ey;
	} script_row_t;

	function automatic script_row_t row_cfg(cfg_index_t index, cfg_data_t data);
		return '{ROW_CFG, index, data, '0, 1'b0, '0, '0};
	endfunction

	function automatic script_row_t row_item(coord_t x, coord_t y);
		return '{ROW_ITEM, REG_COS, x, y, 1'b0, '0, '0};
	endfunction

	function automatic script_row_t row_known(coord_t x, coord_t y, wrap_t ex, coord_t ey);
		return '{ROW_ITEM, REG_COS, x, y, 1'b1, ex, ey};
	endfunction

	logic clk;
	logic arst_n;

	sstm_dest_if #(.COORD_WIDTH(COORD_WIDTH)) dest_ch ();
	sstm_src_if #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) src_ch ();
	sstm_cfg_if cfg_ch ();

	slanted_strip_tiling_map_core #(
		.FRAC_BITS(FRAC_BITS),
		.COORD_WIDTH(COORD_WIDTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.dest(dest_ch),
		.src(src_ch),
		.cfg(cfg_ch)
	);

	logic [COS_W-1:0]    cos_q    = COS_RESET;
	logic [SIN_W-1:0]    sin_q    = SIN_RESET;
	logic [HEIGHT_W-1:0] height_q = HEIGHT_RESET;
	logic [INV_W-1:0]    inv_q    = INV_RESET;
	logic [SHIFT_W-1:0]  shift_q  = SHIFT_RESET;
	logic [SCALE_W-1:0]  scale_q  = SCALE_RESET;

	src_coord_t pending_src[$];
	int errors       = 0;
	int coords_sent  = 0;
	int results_seen = 0;
	int reg_writes   = 0;
	int settings     = 1;
	int idle_pct     = 30;
	int cycle_count  = 0;
	bit quiet_tail   = 1'b0;

	script_row_t script [45] = '{
		row_known(24'h000000, 24'h000000, 17'h00000, 24'h000000),
		row_item(24'h7FFFFF, 24'h7FFFFF),
		row_item(24'h800000, 24'h800000),
		row_item(24'h010000, 24'h000000),
		row_cfg(REG_COS, 24'h010000),
		row_cfg(REG_SIN, 24'h000000),
		row_cfg(REG_HEIGHT, 24'h010000),
		row_cfg(REG_INV, 24'h000000),
		row_cfg(REG_SHIFT, 24'h000000),
		row_cfg(REG_SCALE, 24'h010000),
		row_known(24'h010000, 24'h000000, 17'h10000, 24'h000000),
		row_known(24'h00FFFF, 24'h000005, 17'h0FFFF, 24'h000005),
		row_known(24'hFF0000, 24'h800000, 17'h10000, 24'h800000),
		row_known(24'h800000, 24'h7FFFFF, 17'h00000, 24'h7FFFFF),
		row_known(24'h7FFFFF, 24'hFFFFFF, 17'h1FFFF, 24'hFFFFFF),
		row_cfg(REG_INV, 24'h010000),
		row_known(24'h000000, 24'h008000, 17'h00000, 24'hFF8000),
		row_known(24'h000000, 24'hFF8000, 17'h00000, 24'hFF8000),
		row_known(24'h000000, 24'h007FFF, 17'h00000, 24'h007FFF),
		row_known(24'h000000, 24'h018000, 17'h00000, 24'hFF8000),
		row_cfg(REG_COS, 24'h01FFFF),
		row_cfg(REG_SIN, 24'h01FFFF),
		row_cfg(REG_HEIGHT, 24'h03FFFF),
		row_cfg(REG_INV, 24'hFFFFFF),
		row_cfg(REG_SHIFT, 24'hFFFFFF),
		row_cfg(REG_SCALE, 24'hFFFFFF),
		row_cfg(REG_SPARE, 24'h123456),
		row_item(24'h7FFFFF, 24'h7FFFFF),
		row_item(24'h800000, 24'h7FFFFF),
		row_item(24'h7FFFFF, 24'h800000),
		row_item(24'h12D687, 24'h8B344F),
		row_cfg(REG_COS, 24'h000000),
		row_cfg(REG_SIN, 24'h000000),
		row_cfg(REG_HEIGHT, 24'h000000),
		row_cfg(REG_INV, 24'h000000),
		row_cfg(REG_SHIFT, 24'h000000),
		row_cfg(REG_SCALE, 24'h000000),
		row_known(24'h7FFFFF, 24'h800000, 17'h00000, 24'h000000),
		row_cfg(REG_COS, COS_RESET),
		row_cfg(REG_SIN, SIN_RESET),
		row_cfg(REG_INV, INV_RESET),
		row_cfg(REG_SHIFT, SHIFT_RESET),
		row_cfg(REG_SCALE, SCALE_RESET),
		row_item(24'h0493E0, 24'hF9E580),
		row_item(24'h800000, 24'h7FFFFF)
	};

	function automatic longint saturate(longint v, int w);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			return hi;
		end
		if (v < lo) begin
			return lo;
		end
		return v;
	endfunction

	function automatic src_coord_t map_to_source(coord_t x, coord_t y);
		longint px, py, c, s, h, inv, sh, sc;
		longint rx, ry, strip, sx, sy, ox, oy;
		src_coord_t r;
		px = x;
		py = y;
		c = cos_q;
		s = sin_q;
		h = height_q;
		inv = inv_q;
		sh = shift_q;
		sc = scale_q;
		rx = saturate((px * c + py * s) >>> FRAC_BITS, COORD_WIDTH);
		ry = saturate((py * c - px * s) >>> FRAC_BITS, COORD_WIDTH);
		strip = (ry * inv) >>> (2 * FRAC_BITS - 1);
		strip = saturate((strip + 1) >>> 1, COORD_WIDTH - 1);
		sy = saturate(ry - h * strip, COORD_WIDTH);
		sx = saturate(rx + sh * strip, COORD_WIDTH);
		ox = (sx * sc) >>> FRAC_BITS;
		oy = saturate((sy * sc) >>> FRAC_BITS, COORD_WIDTH);
		r.src_x = ox[SRCX_W-1:0];
		r.src_y = oy[COORD_WIDTH-1:0];
		return r;
	endfunction

	function automatic cfg_data_t rand_setting(int w, int lo, int hi);
		cfg_data_t mask;
		mask = cfg_data_t'((longint'(1) << w) - 1);
		case ($urandom_range(0, 7))
			0: return cfg_data_t'(lo);
			1: return cfg_data_t'(hi);
			2: return cfg_data_t'($urandom) & mask;
			default: return cfg_data_t'(lo + ($urandom % (hi - lo + 1)));
		endcase
	endfunction

	function automatic coord_t rand_coord();
		case ($urandom_range(0, 9))
			0: return coord_t'($urandom);
			1: begin
				case ($urandom_range(0, 4))
					0: return 24'h7FFFFF;
					1: return 24'h800000;
					2: return 24'h000000;
					3: return 24'h000001;
					default: return 24'hFFFFFF;
				endcase
			end
			2, 3, 4, 5: return coord_t'($urandom_range(0, 2 ** 20) - 2 ** 19);
			6, 7: return coord_t'($urandom_range(0, 2 ** 23) - 2 ** 22);
			default: return coord_t'($urandom);
		endcase
	endfunction

	task automatic write_reg(cfg_index_t index, cfg_data_t data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		case (index)
			REG_COS:    cos_q    = data[COS_W-1:0];
			REG_SIN:    sin_q    = data[SIN_W-1:0];
			REG_HEIGHT: height_q = data[HEIGHT_W-1:0];
			REG_INV:    inv_q    = data[INV_W-1:0];
			REG_SHIFT:  shift_q  = data[SHIFT_W-1:0];
			REG_SCALE:  scale_q  = data[SCALE_W-1:0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
	endtask

	task automatic send_coord(coord_t x, coord_t y, bit known, src_coord_t known_src);
		if ($urandom_range(0, 99) < idle_pct) begin
			dest_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		dest_ch.valid  <= 1'b1;
		dest_ch.dest_x <= x;
		dest_ch.dest_y <= y;
		do @(posedge clk); while (!dest_ch.ready);
		pending_src.push_back(known ? known_src : map_to_source(x, y));
		coords_sent++;
		@(negedge clk);
	endtask

	// Hold the input idle until every outstanding coordinate has come out.
	task automatic drain();
		dest_ch.valid <= 1'b0;
		while (pending_src.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timed out after %0d cycles, %0d results outstanding",
			$time, cycle_count, pending_src.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		src_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (!quiet_tail && $urandom_range(0, 399) < idle_pct) begin
				src_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(negedge clk);
			end
			src_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_result
		src_coord_t want;
		if (arst_n && src_ch.valid && src_ch.ready) begin
			results_seen++;
			if (pending_src.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX) begin
					$display("%0t: unexpected result src_x %0d src_y %0d", $time,
						src_ch.src_x, src_ch.src_y);
				end
			end else begin
				want = pending_src.pop_front();
				if (src_ch.src_x !== want.src_x) begin
					errors++;
					if (errors <= REPORT_MAX) begin
						$display("%0t: src_x expected %0d actual %0d", $time,
							want.src_x, src_ch.src_x);
					end
				end
				if (src_ch.src_y !== want.src_y) begin
					errors++;
					if (errors <= REPORT_MAX) begin
						$display("%0t: src_y expected %0d actual %0d", $time,
							want.src_y, src_ch.src_y);
					end
				end
			end
		end
	end

	initial begin
		bit cfg_open;
		int h;
		dest_ch.valid  = 1'b0;
		dest_ch.dest_x = '0;
		dest_ch.dest_y = '0;
		cfg_ch.valid   = 1'b0;
		cfg_ch.index   = REG_COS;
		cfg_ch.data    = '0;
		arst_n         = 1'b0;
		cfg_open       = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (script[i]) begin
			if (script[i].kind == ROW_CFG) begin
				if (!cfg_open) begin
					drain();
					settings++;
				end
				write_reg(script[i].index, script[i].a);
				cfg_open = 1'b1;
			end else begin
				if (cfg_open) begin
					cfg_ch.valid <= 1'b0;
					cfg_open = 1'b0;
				end
				send_coord(script[i].a, script[i].b, script[i].known,
					{script[i].ex, script[i].ey});
			end
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain();
			settings++;
			quiet_tail = (ph == RANDOM_PHASES - 1);
			if (quiet_tail) begin
				idle_pct = 0;
				write_reg(REG_COS, COS_RESET);
				write_reg(REG_SIN, SIN_RESET);
				write_reg(REG_HEIGHT, HEIGHT_RESET);
				write_reg(REG_INV, INV_RESET);
				write_reg(REG_SHIFT, SHIFT_RESET);
				write_reg(REG_SCALE, SCALE_RESET);
			end else begin
				case ($urandom_range(0, 3))
					0: idle_pct = 0;
					1: idle_pct = 5;
					default: idle_pct = 25;
				endcase
				write_reg(REG_COS, rand_setting(COS_W, 0, 65536));
				write_reg(REG_SIN, rand_setting(SIN_W, 0, 65536));
				if ($urandom_range(0, 1) == 0) begin
					h = $urandom_range(8192, 131072);
					write_reg(REG_HEIGHT, cfg_data_t'(h));
					write_reg(REG_INV, cfg_data_t'((longint'(1) << 32) / h));
				end else begin
					write_reg(REG_HEIGHT, rand_setting(HEIGHT_W, 1, 131072));
					write_reg(REG_INV, rand_setting(INV_W, 0, 16777215));
				end
				write_reg(REG_SHIFT, rand_setting(SHIFT_W, 0, 16777215));
				write_reg(REG_SCALE, rand_setting(SCALE_W, 0, 16777215));
			end
			cfg_ch.valid <= 1'b0;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (!quiet_tail && $urandom_range(0, 199) == 0) begin
					drain();
				end
				send_coord(rand_coord(), rand_coord(), 1'b0, '0);
			end
		end
		drain();

		$display("Sent %0d coordinates and checked %0d results under %0d register settings",
			coords_sent, results_seen, settings);
		$display("(%0d register writes, extremes, half-up strip rounding and the wrap point)",
			reg_writes);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
